/* rtl/ksx_pkg.sv */
package ksx_pkg;

  // Default geometry of the key store
  localparam int unsigned KEY_SLOTS_DEF = 8;
  localparam int unsigned KEY_BYTES_DEF = 32;

  // Reset values of the address window
  localparam logic [63:0] WINDOW_START_RST = 64'h0000_0000_4000_0000;
  localparam logic [63:0] WINDOW_END_RST   = 64'h0000_0000_47FF_FFFF;

  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_IMPORT = 1'b0,
    OP_CRYPT  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_DENIED  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  slot_id;
    logic [63:0] buffer_address;
    logic [31:0] request_length;
    logic [7:0]  data_in;
  } ksx_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    status_t    status;
    logic       last;
  } ksx_out_t;

endpackage

/* rtl/key_slot_xor_stream_cipher_unit.sv */
// Key-slot repeating-key XOR cipher. Holds KEY_SLOTS key slots of up to KEY_BYTES
// bytes each, with a stored length per slot. Every input beat carries one byte plus
// the request's opcode, slot, buffer address and length; every beat yields exactly
// one result beat, in order. Import beats write key bytes and set the slot length
// on the request's last beat; crypt beats XOR the byte with the key byte at the
// running key position (wrapping at the slot length). A beat that fails the slot,
// length or address-window checks passes its byte through with an error status and
// stores nothing. Throughput is one beat per clock while out_ready holds high; a
// beat is registered in stage 1 alongside its synchronous key memory read, then in
// the output register, before out_valid rises. The key memory powers up undefined;
// no clearing pass is run, so the block takes beats as soon as reset is released.
// The user must write the window registers through the cfg port only while no
// request is in flight; the block does not enforce this.
module key_slot_xor_stream_cipher_unit #(
  parameter int unsigned KEY_SLOTS = ksx_pkg::KEY_SLOTS_DEF,
  parameter int unsigned KEY_BYTES = ksx_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ksx_pkg::ksx_in_t               in_beat,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output ksx_pkg::ksx_out_t              out_beat,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ksx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int unsigned SW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned KPW   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned KLW   = $clog2(KEY_BYTES + 1);
  localparam int unsigned DEPTH = KEY_SLOTS * KEY_BYTES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Window registers
  logic [63:0] window_start;
  logic [63:0] window_end;

  // Per-slot key length, in flops (reset to zero = empty slot)
  logic [KLW-1:0] key_len [KEY_SLOTS];

  // Request framing and key counters
  logic [31:0]    byte_position;
  logic [KPW-1:0] key_position;

  // Key store: one write port, one registered read port
  logic [7:0] key_mem [DEPTH];
  logic [7:0] mem_rdata;

  // Stage 1: waiting on key memory read data
  logic           s1_valid;
  logic [7:0]     s1_din;
  ksx_pkg::status_t s1_status;
  logic           s1_last;
  logic           s1_xor;

  logic accept;
  logic o_load;

  // Decode of the incoming beat
  logic [31:0]      len;
  logic             len_zero;
  logic             last_c;
  logic             slot_ok;
  logic [SW-1:0]    slot_idx;
  logic [KLW-1:0]   klen;
  logic [63:0]      addr_end;
  logic             win_ok;
  logic             key_fits;
  ksx_pkg::status_t status_c;
  logic             import_ok;
  logic             crypt_ok;
  logic [KPW-1:0]   kp_base;
  logic [KPW-1:0]   kp_sel;
  logic [KLW-1:0]   kp_inc;
  logic [KPW-1:0]   kp_next;
  logic [AW-1:0]    mem_base;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             mem_we;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign o_load    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || o_load;

  assign len      = in_beat.request_length;
  assign len_zero = (len == 32'd0);
  assign last_c   = len_zero || (byte_position >= (len - 32'd1));
  assign slot_ok  = (in_beat.slot_id < 8'(KEY_SLOTS));
  assign slot_idx = in_beat.slot_id[SW-1:0];
  assign klen     = slot_ok ? key_len[slot_idx] : '0;

  // End address wraps modulo 2^64
  assign addr_end = in_beat.buffer_address + 64'(len) - 64'd1;
  assign win_ok   = !len_zero && (in_beat.buffer_address >= window_start) &&
                    (addr_end <= window_end);
  assign key_fits = !len_zero && (len <= 32'(KEY_BYTES));

  always_comb begin
    status_c = ksx_pkg::STATUS_OK;
    if (!slot_ok) begin
      status_c = ksx_pkg::STATUS_INVALID;
    end else if (in_beat.opcode == ksx_pkg::OP_IMPORT && !key_fits) begin
      status_c = ksx_pkg::STATUS_INVALID;
    end else if (in_beat.opcode == ksx_pkg::OP_CRYPT && klen == '0) begin
      status_c = ksx_pkg::STATUS_INVALID;
    end else if (!win_ok) begin
      status_c = ksx_pkg::STATUS_DENIED;
    end
  end

  assign import_ok = (status_c == ksx_pkg::STATUS_OK) && (in_beat.opcode == ksx_pkg::OP_IMPORT);
  assign crypt_ok  = (status_c == ksx_pkg::STATUS_OK) && (in_beat.opcode == ksx_pkg::OP_CRYPT);

  // Key counter: restart on the first beat and whenever it runs past the length
  assign kp_base = (byte_position == 32'd0) ? '0 : key_position;
  assign kp_sel  = (KLW'(kp_base) >= klen) ? '0 : kp_base;
  assign kp_inc  = KLW'(kp_sel) + KLW'(1);
  assign kp_next = (kp_inc >= klen) ? '0 : kp_inc[KPW-1:0];

  // Slot base in the flat key store
  assign mem_base = AW'(slot_idx) * AW'(KEY_BYTES);
  assign rd_addr  = mem_base + AW'(kp_sel);
  assign wr_addr  = mem_base + AW'(byte_position[KPW-1:0]);
  // Bytes past the length are dropped (only with interleaved requests)
  assign mem_we   = accept && import_ok && (byte_position < len);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= in_beat.data_in;
    end
    if (accept) begin
      mem_rdata <= key_mem[rd_addr];
    end
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= ksx_pkg::WINDOW_START_RST;
      window_end   <= ksx_pkg::WINDOW_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ksx_pkg::CFG_WINDOW_START: window_start <= cfg_data;
        ksx_pkg::CFG_WINDOW_END:   window_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot lengths, framing and key counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        key_len[i] <= '0;
      end
      byte_position <= '0;
      key_position  <= '0;
    end else if (accept) begin
      if (import_ok && last_c) begin
        key_len[slot_idx] <= len[KLW-1:0];
      end
      byte_position <= last_c ? 32'd0 : byte_position + 32'd1;
      key_position  <= crypt_ok ? kp_next : '0;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (o_load) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_din    <= in_beat.data_in;
      s1_status <= status_c;
      s1_last   <= last_c;
      s1_xor    <= crypt_ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_beat.data_out <= s1_xor ? (s1_din ^ mem_rdata) : s1_din;
      out_beat.status   <= s1_status;
      out_beat.last     <= s1_last;
    end
  end

`ifndef SYNTH
  // Key store is only written by a clean import beat
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (status_c == ksx_pkg::STATUS_OK) && (in_beat.opcode == ksx_pkg::OP_IMPORT))
    else $error("key store written by a failed or crypt beat");

  // Framing counter returns to zero after a request's last beat
  a_frame_reset: assert property (@(posedge clk) disable iff (rst)
    accept && last_c |=> byte_position == 32'd0)
    else $error("byte position not cleared after last beat");

  // A full stage 1 only takes a new beat when it drains the same cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid |-> o_load)
    else $error("stage 1 overwritten while holding a beat");

  // XOR only applied to beats that passed all checks
  a_xor_ok: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_xor |-> s1_status == ksx_pkg::STATUS_OK)
    else $error("XOR applied to an error beat");
`endif

endmodule
